@@ rtl/core/tcf_pkg.sv @@
package tcf_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned RawW = 16;
  localparam int unsigned OutW = 25;
  localparam int unsigned WeightW = 17;
  localparam int unsigned GainW = 10;
  localparam int unsigned AngleFracBitsDef = 16;
  localparam int unsigned CordicSteps = 24;
  localparam int unsigned TabFrac = 24;
  localparam int unsigned StepW = 5;
  // cordic datapath width: 16-bit magnitude shifted by 24, growth, sign
  localparam int unsigned CordW = 44;
  // angle accumulator width in table units (Q24)
  localparam int unsigned AccW = 34;

  localparam logic [CfgIdxW-1:0] CfgBlendWeight = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGyroGain = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgGyroOffset = 2'd2;

  localparam logic [WeightW-1:0] WeightOne = 17'd65536;

  typedef struct packed {
    logic signed [RawW-1:0] acc_x;
    logic signed [RawW-1:0] acc_z;
    logic signed [RawW-1:0] gyro_y;
  } sample_t;

  function automatic logic [AccW-1:0] atan_tab(input logic [StepW-1:0] i);
    logic [AccW-1:0] r;
    case (i)
      5'd0: r = 34'd754974720;
      5'd1: r = 34'd445687602;
      5'd2: r = 34'd235489089;
      5'd3: r = 34'd119537938;
      5'd4: r = 34'd60000934;
      5'd5: r = 34'd30029717;
      5'd6: r = 34'd15018523;
      5'd7: r = 34'd7509720;
      5'd8: r = 34'd3754917;
      5'd9: r = 34'd1877466;
      5'd10: r = 34'd938734;
      5'd11: r = 34'd469367;
      5'd12: r = 34'd234684;
      5'd13: r = 34'd117342;
      5'd14: r = 34'd58671;
      5'd15: r = 34'd29335;
      5'd16: r = 34'd14668;
      5'd17: r = 34'd7334;
      5'd18: r = 34'd3667;
      5'd19: r = 34'd1833;
      5'd20: r = 34'd917;
      5'd21: r = 34'd458;
      5'd22: r = 34'd229;
      5'd23: r = 34'd115;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/tcf_cordic.sv @@
module tcf_cordic #(
  parameter int unsigned AngleFracBits = tcf_pkg::AngleFracBitsDef,
  parameter int unsigned AngW = AngleFracBits + 9
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [tcf_pkg::RawW-1:0] y_i,
  input  logic signed [tcf_pkg::RawW-1:0] x_i,
  output logic                            done_o,
  output logic signed [AngW-1:0]          angle_o
);
  import tcf_pkg::*;

  localparam int unsigned Sh = TabFrac - AngleFracBits;
  localparam logic signed [AccW-1:0] Deg180 = AccW'(180) <<< TabFrac;
  localparam logic signed [AccW-1:0] Deg90 = AccW'(90) <<< TabFrac;
  localparam logic signed [AccW-1:0] Half = AccW'(1) <<< (Sh - 1);

  logic busy_q, busy_d;
  logic [StepW-1:0] step_q, step_d;
  logic signed [CordW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic done_q, done_d;
  logic signed [CordW-1:0] xe, ye, dx, dy;
  logic signed [AccW-1:0] rnd;

  always_comb begin
    xe = CordW'(x_i);
    ye = CordW'(y_i);
    dx = y_q >>> step_q;
    dy = x_q >>> step_q;
    busy_d = busy_q;
    step_d = step_q;
    x_d = x_q;
    y_d = y_q;
    acc_d = acc_q;
    done_d = 1'b0;
    if (start_i) begin
      step_d = '0;
      if (y_i == '0) begin
        acc_d = (x_i < 0) ? Deg180 : '0;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else if (x_i == '0) begin
        acc_d = (y_i > 0) ? Deg90 : -Deg90;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        busy_d = 1'b1;
        if (x_i < 0) begin
          acc_d = (y_i >= 0) ? Deg180 : -Deg180;
          x_d = (-xe) <<< TabFrac;
          y_d = (-ye) <<< TabFrac;
        end else begin
          acc_d = '0;
          x_d = xe <<< TabFrac;
          y_d = ye <<< TabFrac;
        end
      end
    end else if (busy_q) begin
      if (!y_q[CordW-1]) begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        acc_d = acc_q + $signed(atan_tab(step_q));
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        acc_d = acc_q - $signed(atan_tab(step_q));
      end
      step_d = step_q + 1'b1;
      if (step_q == StepW'(CordicSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    acc_q <= acc_d;
  end

  assign rnd = (acc_q + Half) >>> Sh;
  assign done_o = done_q;
  assign angle_o = AngW'(rnd);

endmodule

@@ rtl/core/tilt_complementary_filter_core.sv @@
// channel   dir  handshake                          payload
// s_axis    in   s_axis_tvalid/s_axis_tready        acc_x, acc_z, gyro_y
// m_axis    out  m_axis_tvalid/m_axis_tready        accel_angle, gyro_angle, fused_angle
// cfg       in   cfg_valid_i/cfg_ready_o            cfg_index_i, cfg_data_i
// one item passes, from accept to the next accept, through 24 cordic steps
// (iterative shift-add unit), the round and product step, the blend step,
// the output step, where a stalled result waits, and the idle step.
// the 0/180 and +/-90 degree shortcuts for a zero input skip the cordic steps.
// reset clears the fused angle to zero and the configuration registers to their defaults.
// a stalled result holds in the output register; the next item is taken
// only after the result has left.
module tilt_complementary_filter_core #(
  parameter int unsigned AngleFracBits = tcf_pkg::AngleFracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // acc_x [15:0], acc_z [31:16], gyro_y [47:32]
  input  logic [47:0]                s_axis_tdata,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // accel_angle [24:0], gyro_angle [49:25], fused_angle [74:50], zero fill
  output logic [79:0]                m_axis_tdata,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [tcf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                cfg_data_i
);
  import tcf_pkg::*;

  localparam int unsigned AngW = AngleFracBits + 9;
  localparam int unsigned WideW = AngW + 12;
  localparam logic signed [AngW-1:0] AngMax = AngW'(180) <<< AngleFracBits;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StAtan = 2'd1;
  localparam logic [1:0] StBlend = 2'd2;
  localparam logic [1:0] StOut = 2'd3;

  logic [1:0] st_q, st_d;
  logic [WeightW-1:0] weight_q;
  logic [GainW-1:0] gain_q;
  logic signed [RawW-1:0] offset_q;
  logic signed [AngW-1:0] fused_q, acc_ang_q, gyr_ang_q, new_fused_q;
  logic signed [AngW-1:0] cord_ang, acc_sat, gyr_sat, fus_sat;
  logic signed [RawW:0] gdiff_q;
  logic signed [WideW-1:0] gsum;
  logic signed [AngW+18:0] mac_q, mac_sum;
  logic [WeightW-1:0] w_eff;
  logic cord_done;
  logic take_in;
  sample_t smp;

  assign smp = sample_t'({s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tdata[47:32]});
  assign s_axis_tready = (st_q == StIdle);
  assign take_in = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  tcf_cordic #(.AngleFracBits(AngleFracBits), .AngW(AngW)) u_cordic (
    .clk_i, .rst_ni,
    .start_i(take_in),
    .y_i(smp.acc_x),
    .x_i(smp.acc_z),
    .done_o(cord_done),
    .angle_o(cord_ang)
  );

  function automatic logic signed [AngW-1:0] sat_w(input logic signed [AngW+18:0] v);
    logic signed [AngW+18:0] m;
    m = (AngW+19)'(AngMax);
    if (v > m) return AngMax;
    if (v < -m) return -AngMax;
    return AngW'(v);
  endfunction

  always_comb begin
    w_eff = (weight_q > WeightOne) ? WeightOne : weight_q;
    acc_sat = sat_w(-(AngW+19)'(cord_ang));
    gsum = WideW'(fused_q) + WideW'(gdiff_q) * $signed({1'b0, gain_q});
    gyr_sat = sat_w((AngW+19)'(gsum));
    mac_sum = mac_q + $signed({1'b0, WeightOne - w_eff}) * gyr_ang_q
              + (AngW+19)'(32768);
    fus_sat = sat_w(mac_sum >>> 16);
    st_d = st_q;
    case (st_q)
      StIdle: if (take_in) st_d = StAtan;
      StAtan: if (cord_done) st_d = StBlend;
      StBlend: st_d = StOut;
      StOut: if (m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      weight_q <= 17'd66;
      gain_q <= 10'd4;
      offset_q <= '0;
      fused_q <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgBlendWeight: weight_q <= cfg_data_i[WeightW-1:0];
          CfgGyroGain: gain_q <= cfg_data_i[GainW-1:0];
          CfgGyroOffset: offset_q <= cfg_data_i[RawW-1:0];
          default: ;
        endcase
      end
      if (st_q == StBlend) fused_q <= fus_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) gdiff_q <= (RawW+1)'(smp.gyro_y) - (RawW+1)'(offset_q);
    if (st_q == StAtan && cord_done) begin
      acc_ang_q <= acc_sat;
      gyr_ang_q <= gyr_sat;
      mac_q <= $signed({1'b0, w_eff}) * acc_sat;
    end
    if (st_q == StBlend) new_fused_q <= fus_sat;
  end

  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tdata = {5'd0, 25'(new_fused_q), 25'(gyr_ang_q), 25'(acc_ang_q)};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("item taken while busy");
  a_fused_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fused_q <= AngMax) && (fused_q >= -AngMax)) else $error("fused out of range");

endmodule
